// ===== hdl/sie_pkg.sv =====
// shared types, constants and helpers for the swerve icr estimator
`timescale 1ns / 1ps
package sie_pkg;

  localparam int CordicStages = 16;
  localparam int AngW = 17;
  localparam int RegW = 32;
  localparam int ThrW = 31;
  localparam logic [30:0] ThrReset = 31'd10737;
  localparam logic signed [31:0] CordicInvGain = 32'sd652032874;
  localparam logic signed [63:0] Q30One = 64'sd1073741824;

  typedef enum logic [2:0] {
    REG_LEFT_X  = 3'd0,
    REG_LEFT_Y  = 3'd1,
    REG_RIGHT_X = 3'd2,
    REG_RIGHT_Y = 3'd3,
    REG_BACK_X  = 3'd4,
    REG_BACK_Y  = 3'd5,
    REG_THRESH  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } vec2_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] w;
  } hvec_t;

  // arctangent table in q30, 2^-i
  function automatic logic signed [31:0] atan_q30(input int i);
    logic signed [31:0] t;
    case (i)
      0: t = 32'sd843314857;
      1: t = 32'sd497837829;
      2: t = 32'sd263043837;
      3: t = 32'sd133525159;
      4: t = 32'sd67021687;
      5: t = 32'sd33543516;
      6: t = 32'sd16775851;
      7: t = 32'sd8388437;
      8: t = 32'sd4194283;
      9: t = 32'sd2097149;
      10: t = 32'sd1048576;
      11: t = 32'sd524288;
      12: t = 32'sd262144;
      13: t = 32'sd131072;
      14: t = 32'sd65536;
      15: t = 32'sd32768;
      16: t = 32'sd16384;
      17: t = 32'sd8192;
      18: t = 32'sd4096;
      19: t = 32'sd2048;
      20: t = 32'sd1024;
      21: t = 32'sd512;
      22: t = 32'sd256;
      23: t = 32'sd128;
      default: t = 32'sd0;
    endcase
    return t;
  endfunction

  function automatic logic signed [31:0] clamp_unit(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd1073741824) r = 32'sd1073741824;
    else if (v < -34'sd1073741824) r = -32'sd1073741824;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== hdl/sie_dir.sv =====
// pipelined angle reduction and cordic giving one wheel-axis direction
`timescale 1ns / 1ps
module sie_dir import sie_pkg::*; (
  input  logic                   clk,
  input  logic signed [AngW-1:0] in_angle,
  output vec2_t                  out_dir
);

  // reduce modulo 36000 and split into quadrant and remainder
  // offset by 72000 so the value is positive, then subtract whole turns
  logic [18:0] m0;
  logic [15:0] m_r;
  logic [15:0] m_nxt;
  always_comb begin
    m0 = 19'(19'(in_angle) + 19'sd72000);
    if (m0 >= 19'd108000) m0 = m0 - 19'd108000;
    else if (m0 >= 19'd72000) m0 = m0 - 19'd72000;
    else if (m0 >= 19'd36000) m0 = m0 - 19'd36000;
    m_nxt = m0[15:0];
  end
  always_ff @(posedge clk) begin
    m_r <= m_nxt;
  end

  logic [1:0] q_nxt;
  logic [13:0] rem_nxt;
  always_comb begin
    if (m_r >= 16'd27000) begin
      q_nxt = 2'd3; rem_nxt = 14'(m_r - 16'd27000);
    end else if (m_r >= 16'd18000) begin
      q_nxt = 2'd2; rem_nxt = 14'(m_r - 16'd18000);
    end else if (m_r >= 16'd9000) begin
      q_nxt = 2'd1; rem_nxt = 14'(m_r - 16'd9000);
    end else begin
      q_nxt = 2'd0; rem_nxt = 14'(m_r);
    end
  end
  logic [1:0] q_r;
  logic [13:0] rem_r;
  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    rem_r <= rem_nxt;
  end

  logic signed [33:0] z0_nxt;
  logic [42:0] prod;
  always_comb begin
    prod = 43'(rem_r) * 43'd191900981 + 43'd512;
    z0_nxt = 34'(prod >> 10);
  end

  logic signed [33:0] cx_r [CordicStages+1];
  logic signed [33:0] cy_r [CordicStages+1];
  logic signed [33:0] cz_r [CordicStages+1];
  logic [1:0] cq_r [CordicStages+1];

  always_ff @(posedge clk) begin
    cx_r[0] <= 34'(CordicInvGain);
    cy_r[0] <= '0;
    cz_r[0] <= z0_nxt;
    cq_r[0] <= q_r;
  end

  for (genvar i = 0; i < CordicStages; i++) begin : g_stage
    logic signed [33:0] xs, ys, at;
    assign xs = cx_r[i] >>> i;
    assign ys = cy_r[i] >>> i;
    assign at = 34'(atan_q30(i));
    always_ff @(posedge clk) begin
      if (cz_r[i] >= 0) begin
        cx_r[i+1] <= cx_r[i] - ys;
        cy_r[i+1] <= cy_r[i] + xs;
        cz_r[i+1] <= cz_r[i] - at;
      end else begin
        cx_r[i+1] <= cx_r[i] + ys;
        cy_r[i+1] <= cy_r[i] - xs;
        cz_r[i+1] <= cz_r[i] + at;
      end
      cq_r[i+1] <= cq_r[i];
    end
  end

  logic signed [31:0] s, c;
  vec2_t dir_nxt, dir_r;
  always_comb begin
    s = clamp_unit(cy_r[CordicStages]);
    c = clamp_unit(cx_r[CordicStages]);
    case (cq_r[CordicStages])
      2'd0: begin dir_nxt.x = s;  dir_nxt.y = -c; end
      2'd1: begin dir_nxt.x = c;  dir_nxt.y = s;  end
      2'd2: begin dir_nxt.x = -s; dir_nxt.y = c;  end
      default: begin dir_nxt.x = -c; dir_nxt.y = -s; end
    endcase
  end
  always_ff @(posedge clk) begin
    dir_r <= dir_nxt;
  end
  assign out_dir = dir_r;

endmodule

// ===== hdl/sie_div.sv =====
// pipelined restoring divider, one quotient bit per stage, truncating
`timescale 1ns / 1ps
module sie_div import sie_pkg::*; (
  input  logic               clk,
  input  logic signed [63:0] in_num,
  input  logic        [31:0] in_den,
  output logic signed [63:0] out_quo
);

  // magnitude divide; den is positive
  logic [63:0] rq_r [65];
  logic [32:0] rr_r [65];
  logic        rs_r [65];
  logic [31:0] rd_r [65];

  always_ff @(posedge clk) begin
    rq_r[0] <= in_num[63] ? 64'(-in_num) : 64'(in_num);
    rr_r[0] <= '0;
    rs_r[0] <= in_num[63];
    rd_r[0] <= in_den;
  end

  for (genvar i = 0; i < 64; i++) begin : g_bit
    logic [33:0] t;
    assign t = {rr_r[i], rq_r[i][63]};
    always_ff @(posedge clk) begin
      rs_r[i+1] <= rs_r[i];
      rd_r[i+1] <= rd_r[i];
      if (t >= {2'b0, rd_r[i]}) begin
        rr_r[i+1] <= 33'(t - {2'b0, rd_r[i]});
        rq_r[i+1] <= {rq_r[i][62:0], 1'b1};
      end else begin
        rr_r[i+1] <= t[32:0];
        rq_r[i+1] <= {rq_r[i][62:0], 1'b0};
      end
    end
  end

  assign out_quo = rs_r[64] ? -$signed(rq_r[64]) : $signed(rq_r[64]);

endmodule

// ===== hdl/sie_pair.sv =====
// pipelined line-pair intersection on the unit homogeneous sphere
`timescale 1ns / 1ps
module sie_pair import sie_pkg::*; (
  input  logic                   clk,
  input  vec2_t                  in_p1,
  input  vec2_t                  in_d1,
  input  vec2_t                  in_p2,
  input  vec2_t                  in_d2,
  input  logic        [ThrW-1:0] in_thr,
  output hvec_t                  out_h
);

  // stage 1: products for cross and n
  logic signed [63:0] c1_r, c2_r;
  logic signed [32:0] ex_r, ey_r;
  vec2_t d1_a_r, d2_a_r, p1_a_r;
  logic [ThrW-1:0] thr_a_r;
  always_ff @(posedge clk) begin
    c1_r <= 64'(in_d1.x) * 64'(in_d2.y);
    c2_r <= 64'(in_d1.y) * 64'(in_d2.x);
    ex_r <= 33'(in_p2.x) - 33'(in_p1.x);
    ey_r <= 33'(in_p2.y) - 33'(in_p1.y);
    d1_a_r <= in_d1; d2_a_r <= in_d2; p1_a_r <= in_p1;
    thr_a_r <= in_thr;
  end

  // stage 2: cross, n products
  logic signed [31:0] c_r;
  logic signed [65:0] n1_r, n2_r;
  vec2_t d1_b_r, p1_b_r;
  logic [ThrW-1:0] thr_b_r;
  always_ff @(posedge clk) begin
    c_r <= 32'((c1_r - c2_r) >>> 30);
    n1_r <= 66'(ex_r) * 66'(d2_a_r.y);
    n2_r <= 66'(ey_r) * 66'(d2_a_r.x);
    d1_b_r <= d1_a_r; p1_b_r <= p1_a_r; thr_b_r <= thr_a_r;
  end

  // stage 3: parallel test, n, c*p
  logic signed [65:0] nfull;
  logic signed [49:0] n_c_r;
  logic signed [63:0] cpx_r, cpy_r;
  logic par_c_r;
  logic signed [31:0] c_c_r;
  vec2_t d1_c_r;
  logic [31:0] ac;
  always_comb begin
    nfull = (n1_r - n2_r) >>> 16;
    ac = c_r[31] ? 32'(-c_r) : 32'(c_r);
  end
  always_ff @(posedge clk) begin
    n_c_r <= 50'(nfull);
    cpx_r <= 64'(c_r) * 64'(p1_b_r.x);
    cpy_r <= 64'(c_r) * 64'(p1_b_r.y);
    par_c_r <= (ac < {1'b0, thr_b_r}) || (c_r == 0);
    c_c_r <= c_r;
    d1_c_r <= d1_b_r;
  end

  // stage 4: n*d1 split into high and low partial products
  logic signed [49:0] nh;
  logic signed [25:0] nl;
  logic signed [63:0] thx_r, thy_r, ulx_r, uly_r;
  logic signed [63:0] cpx_d_r, cpy_d_r;
  logic par_d_r;
  logic signed [31:0] c_d_r;
  vec2_t d1_d_r;
  always_comb begin
    nh = n_c_r >>> 24;
    nl = 26'(n_c_r - (nh <<< 24));
  end
  always_ff @(posedge clk) begin
    thx_r <= 64'(nh) * 64'(d1_c_r.x);
    thy_r <= 64'(nh) * 64'(d1_c_r.y);
    ulx_r <= 64'(nl) * 64'(d1_c_r.x);
    uly_r <= 64'(nl) * 64'(d1_c_r.y);
    cpx_d_r <= cpx_r >>> 16; cpy_d_r <= cpy_r >>> 16;
    par_d_r <= par_c_r; c_d_r <= c_c_r; d1_d_r <= d1_c_r;
  end

  // stage 5: combine mul_q30 terms
  function automatic logic signed [63:0] mq(input logic signed [63:0] t,
                                            input logic signed [63:0] u);
    logic signed [63:0] th, tl;
    th = t >>> 6;
    tl = t - (th <<< 6);
    return th + (((tl <<< 24) + u) >>> 30);
  endfunction

  logic signed [63:0] vx_e_r, vy_e_r, vw_e_r;
  logic par_e_r;
  vec2_t d1_e_r;
  always_ff @(posedge clk) begin
    logic signed [63:0] vx, vy;
    vx = cpx_d_r + mq(thx_r, ulx_r);
    vy = cpy_d_r + mq(thy_r, uly_r);
    if (c_d_r < 0) begin
      vx_e_r <= -vx; vy_e_r <= -vy; vw_e_r <= -64'(c_d_r);
    end else begin
      vx_e_r <= vx; vy_e_r <= vy; vw_e_r <= 64'(c_d_r);
    end
    par_e_r <= par_d_r; d1_e_r <= d1_d_r;
  end

  // stage 6: normalize largest magnitude into [2^29, 2^30)
  function automatic logic [63:0] mag(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  logic [63:0] mm;
  logic [6:0] lz;
  logic signed [31:0] nx_f_r, ny_f_r, nw_f_r;
  logic par_f_r;
  vec2_t d1_f_r;
  always_comb begin
    mm = mag(vx_e_r);
    if (mag(vy_e_r) > mm) mm = mag(vy_e_r);
    if (mag(vw_e_r) > mm) mm = mag(vw_e_r);
    lz = 7'd0;
    for (int b = 0; b < 64; b++) if (mm[b]) lz = 7'(b);
  end
  always_ff @(posedge clk) begin
    if (lz >= 7'd29) begin
      nx_f_r <= 32'(vx_e_r >>> (lz - 7'd29));
      ny_f_r <= 32'(vy_e_r >>> (lz - 7'd29));
      nw_f_r <= 32'(vw_e_r >>> (lz - 7'd29));
    end else begin
      nx_f_r <= 32'(vx_e_r <<< (7'd29 - lz));
      ny_f_r <= 32'(vy_e_r <<< (7'd29 - lz));
      nw_f_r <= 32'(vw_e_r <<< (7'd29 - lz));
    end
    par_f_r <= par_e_r; d1_f_r <= d1_e_r;
  end

  // stage 7: squares
  logic [63:0] sq_g_r;
  logic signed [31:0] nx_g_r, ny_g_r, nw_g_r;
  logic par_g_r;
  vec2_t d1_g_r;
  always_ff @(posedge clk) begin
    sq_g_r <= 64'(64'(nx_f_r) * 64'(nx_f_r)) + 64'(64'(ny_f_r) * 64'(ny_f_r))
              + 64'(64'(nw_f_r) * 64'(nw_f_r));
    nx_g_r <= nx_f_r; ny_g_r <= ny_f_r; nw_g_r <= nw_f_r;
    par_g_r <= par_f_r; d1_g_r <= d1_f_r;
  end

  // stages: square root, one result bit per stage
  localparam int SqSt = 32;
  logic [63:0] sv_r [SqSt+1];
  logic [63:0] sres_r [SqSt+1];
  logic signed [31:0] sx_r [SqSt+1];
  logic signed [31:0] sy_r [SqSt+1];
  logic signed [31:0] sw_r [SqSt+1];
  logic sp_r [SqSt+1];
  vec2_t sd_r [SqSt+1];
  always_comb begin
    sv_r[0] = sq_g_r; sres_r[0] = '0;
    sx_r[0] = nx_g_r; sy_r[0] = ny_g_r; sw_r[0] = nw_g_r;
    sp_r[0] = par_g_r; sd_r[0] = d1_g_r;
  end
  for (genvar i = 0; i < SqSt; i++) begin : g_sqrt
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * i);
    always_ff @(posedge clk) begin
      if (sv_r[i] >= sres_r[i] + Bit) begin
        sv_r[i+1] <= sv_r[i] - (sres_r[i] + Bit);
        sres_r[i+1] <= (sres_r[i] >> 1) + Bit;
      end else begin
        sv_r[i+1] <= sv_r[i];
        sres_r[i+1] <= sres_r[i] >> 1;
      end
      sx_r[i+1] <= sx_r[i]; sy_r[i+1] <= sy_r[i]; sw_r[i+1] <= sw_r[i];
      sp_r[i+1] <= sp_r[i]; sd_r[i+1] <= sd_r[i];
    end
  end

  // three dividers; delay line for parallel bypass
  logic signed [63:0] qx, qy, qw;
  logic [31:0] nr;
  assign nr = 32'(sres_r[SqSt]);
  sie_div u_divx (.clk, .in_num(64'(sx_r[SqSt]) <<< 30), .in_den(nr), .out_quo(qx));
  sie_div u_divy (.clk, .in_num(64'(sy_r[SqSt]) <<< 30), .in_den(nr), .out_quo(qy));
  sie_div u_divw (.clk, .in_num(64'(sw_r[SqSt]) <<< 30), .in_den(nr), .out_quo(qw));

  logic dp_r [65];
  vec2_t dd_r [65];
  always_ff @(posedge clk) begin
    dp_r[0] <= sp_r[SqSt];
    dd_r[0] <= sd_r[SqSt];
  end
  for (genvar i = 0; i < 64; i++) begin : g_dly
    always_ff @(posedge clk) begin
      dp_r[i+1] <= dp_r[i];
      dd_r[i+1] <= dd_r[i];
    end
  end

  hvec_t h_r;
  always_ff @(posedge clk) begin
    if (dp_r[64]) begin
      h_r.x <= dd_r[64].x; h_r.y <= dd_r[64].y; h_r.w <= '0;
    end else begin
      h_r.x <= 32'(qx); h_r.y <= 32'(qy); h_r.w <= 32'(qw);
    end
  end
  assign out_h = h_r;

endmodule

// ===== hdl/swerve_icr_estimator.sv =====
// top level: swerve drive rotation-centre estimator
//
//  channel  ports                          handshake
//  input    in_left/right/back_angle       start & !busy
//  result   out_avg_h*, out_centre_*       out_valid, one cycle
//  config   cfg_we, cfg_index, cfg_data    cfg_we, immediate
//
// one word enters per cycle; busy is tied low. each word passes through the cordic,
// square root and two divider chains on its way from accept to result.
// rst_n clears only the valid line and config registers (threshold to ThrReset); data stages hold no reset.
// results cannot be stalled, so the pipeline never stops.
`timescale 1ns / 1ps
module swerve_icr_estimator import sie_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [AngW-1:0] in_left_angle,
  input  logic signed [AngW-1:0] in_right_angle,
  input  logic signed [AngW-1:0] in_back_angle,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [RegW-1:0]        cfg_data,
  output logic                   out_valid,
  output logic signed [31:0]     out_avg_hx,
  output logic signed [31:0]     out_avg_hy,
  output logic signed [31:0]     out_avg_hw,
  output logic signed [31:0]     out_centre_x,
  output logic signed [31:0]     out_centre_y,
  output logic                   out_centre_infinite
);

  localparam int Lat = 4 + CordicStages + 7 + 32 + 65 + 1 + 3 + 65 + 1;

  vec2_t pl_r, pr_r, pb_r;
  logic [ThrW-1:0] thr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pl_r <= '0; pr_r <= '0; pb_r <= '0; thr_r <= ThrReset;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEFT_X:  pl_r.x <= cfg_data;
        REG_LEFT_Y:  pl_r.y <= cfg_data;
        REG_RIGHT_X: pr_r.x <= cfg_data;
        REG_RIGHT_Y: pr_r.y <= cfg_data;
        REG_BACK_X:  pb_r.x <= cfg_data;
        REG_BACK_Y:  pb_r.y <= cfg_data;
        REG_THRESH:  thr_r <= cfg_data[ThrW-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  vec2_t dl, dr, db;
  sie_dir u_dirl (.clk, .in_angle(in_left_angle),  .out_dir(dl));
  sie_dir u_dirr (.clk, .in_angle(in_right_angle), .out_dir(dr));
  sie_dir u_dirb (.clk, .in_angle(in_back_angle),  .out_dir(db));

  hvec_t h0, h1, h2;
  sie_pair u_pair0 (.clk, .in_p1(pl_r), .in_d1(dl), .in_p2(pr_r), .in_d2(dr),
                    .in_thr(thr_r), .out_h(h0));
  sie_pair u_pair1 (.clk, .in_p1(pb_r), .in_d1(db), .in_p2(pl_r), .in_d2(dl),
                    .in_thr(thr_r), .out_h(h1));
  sie_pair u_pair2 (.clk, .in_p1(pb_r), .in_d1(db), .in_p2(pr_r), .in_d2(dr),
                    .in_thr(thr_r), .out_h(h2));

  // dot products for sign alignment
  logic signed [65:0] dot1_r, dot2_r;
  hvec_t a0_r, a1_r, a2_r;
  always_ff @(posedge clk) begin
    dot1_r <= 66'(64'(h0.x) * 64'(h1.x)) + 66'(64'(h0.y) * 64'(h1.y))
              + 66'(64'(h0.w) * 64'(h1.w));
    dot2_r <= 66'(64'(h0.x) * 64'(h2.x)) + 66'(64'(h0.y) * 64'(h2.y))
              + 66'(64'(h0.w) * 64'(h2.w));
    a0_r <= h0; a1_r <= h1; a2_r <= h2;
  end

  // align signs against pair 0 and sum; the divide by three follows
  logic signed [33:0] sx_r, sy_r, sw_r;
  always_ff @(posedge clk) begin
    logic signed [33:0] f1x, f1y, f1w, f2x, f2y, f2w;
    f1x = dot1_r < 0 ? -34'(a1_r.x) : 34'(a1_r.x);
    f1y = dot1_r < 0 ? -34'(a1_r.y) : 34'(a1_r.y);
    f1w = dot1_r < 0 ? -34'(a1_r.w) : 34'(a1_r.w);
    f2x = dot2_r < 0 ? -34'(a2_r.x) : 34'(a2_r.x);
    f2y = dot2_r < 0 ? -34'(a2_r.y) : 34'(a2_r.y);
    f2w = dot2_r < 0 ? -34'(a2_r.w) : 34'(a2_r.w);
    sx_r <= 34'(a0_r.x) + f1x + f2x;
    sy_r <= 34'(a0_r.y) + f1y + f2y;
    sw_r <= 34'(a0_r.w) + f1w + f2w;
  end

  // divide by three via reciprocal multiply on magnitude
  function automatic logic signed [31:0] div3(input logic signed [33:0] v);
    logic [33:0] m;
    logic [67:0] p;
    logic [33:0] q;
    m = v[33] ? 34'(-v) : 34'(v);
    p = 68'(m) * 68'h0AAAAAAAB;
    q = 34'(p >> 33);
    return v[33] ? 32'(-q) : 32'(q);
  endfunction

  hvec_t avg_r;
  always_ff @(posedge clk) begin
    avg_r.x <= div3(sx_r);
    avg_r.y <= div3(sy_r);
    avg_r.w <= div3(sw_r);
  end

  // centre: sign-fix so the divider sees a positive denominator
  logic wneg;
  logic [31:0] wmag;
  logic signed [63:0] numx, numy, qx, qy;
  assign wneg = avg_r.w[31];
  assign wmag = wneg ? 32'(-avg_r.w) : 32'(avg_r.w);
  assign numx = wneg ? -(64'(avg_r.x) <<< 16) : (64'(avg_r.x) <<< 16);
  assign numy = wneg ? -(64'(avg_r.y) <<< 16) : (64'(avg_r.y) <<< 16);
  sie_div u_cdivx (.clk, .in_num(numx), .in_den(wmag), .out_quo(qx));
  sie_div u_cdivy (.clk, .in_num(numy), .in_den(wmag), .out_quo(qy));

  hvec_t avd_r [65];
  always_ff @(posedge clk) avd_r[0] <= avg_r;
  for (genvar i = 0; i < 64; i++) begin : g_avd
    always_ff @(posedge clk) avd_r[i+1] <= avd_r[i];
  end

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  logic [Lat-1:0] vld_r;
  logic [Lat-1:0] vld_nxt;
  assign vld_nxt = {vld_r[Lat-2:0], start & ~busy};
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= vld_nxt;
  end

  hvec_t o_avg_r;
  logic signed [31:0] o_cx_r, o_cy_r;
  logic o_inf_r;
  always_ff @(posedge clk) begin
    o_avg_r <= avd_r[64];
    o_inf_r <= avd_r[64].w == 0;
    o_cx_r <= avd_r[64].w == 0 ? 32'sh7FFFFFFF : sat32(qx);
    o_cy_r <= avd_r[64].w == 0 ? 32'sh7FFFFFFF : sat32(qy);
  end

  assign out_valid = vld_r[Lat-1];
  assign out_avg_hx = o_avg_r.x;
  assign out_avg_hy = o_avg_r.y;
  assign out_avg_hw = o_avg_r.w;
  assign out_centre_x = o_cx_r;
  assign out_centre_y = o_cy_r;
  assign out_centre_infinite = o_inf_r;

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] |-> ##(Lat-1) out_valid) else $error("result lost in pipeline");
  a_inf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_centre_infinite |-> out_avg_hw == 0 &&
    out_centre_x == 32'sh7FFFFFFF) else $error("infinite flag mismatch");

endmodule
